[rtl/assert_macros.svh]
// Assertion macros used by the DFA matcher core RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define DFAM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication checked outside reset.
`define DFAM_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

[rtl/dfam_pkg.sv]
// Shared types, codes and helper functions for the DFA matcher.
// No dependencies; the core, front end and back end refer to it by scoped names.
`default_nettype none

package dfam_pkg;

	localparam int DEFAULT_MAX_STATES  = 16;
	localparam int DEFAULT_SYMBOL_BITS = 8;

	localparam int STATE_FLD_W = 4;
	localparam int SYM_FLD_W   = 8;
	localparam int NSTATES_W   = 5;
	localparam int MASK_W      = 16;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	localparam logic [1:0] OP_ADD_SYM   = 2'd0;
	localparam logic [1:0] OP_ADD_TRANS = 2'd1;
	localparam logic [1:0] OP_FEED      = 2'd2;

	localparam logic [1:0] REG_NUM_STATES  = 2'd0;
	localparam logic [1:0] REG_START_STATE = 2'd1;
	localparam logic [1:0] REG_FINAL_MASK  = 2'd2;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_ACCEPT         = 3'd1,
		ST_REJECT         = 3'd2,
		ST_BAD_STRING_SYM = 3'd3,
		ST_BAD_TRANS_SYM  = 3'd4,
		ST_BAD_FROM       = 3'd5,
		ST_BAD_TO         = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [SYM_FLD_W-1:0]   symbol;
		logic [STATE_FLD_W-1:0] from_state;
		logic [STATE_FLD_W-1:0] to_state;
		logic                   last;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       done_res;
	} result_t;

	// Input item after classification by the front end.
	typedef struct packed {
		logic [1:0]             opcode;
		logic [SYM_FLD_W-1:0]   symbol;
		logic [STATE_FLD_W-1:0] from_state;
		logic [STATE_FLD_W-1:0] to_state;
		logic                   last;
		logic                   sym_in_range;
		logic                   from_ok;
		logic                   to_ok;
		logic                   start_ok;
	} cls_t;

	// A state number is known when it is below both the programmed count and the table size.
	function automatic logic state_known(input logic [STATE_FLD_W-1:0] st,
	                                     input logic [NSTATES_W-1:0] cnt,
	                                     input int unsigned max_states);
		return (NSTATES_W'(st) < cnt) && (32'(st) < max_states);
	endfunction

endpackage

`default_nettype wire

[rtl/table_driven_dfa_matcher_core.sv]
// Items pass the command queue, the table-read stage and the result queue in that order.
// Throughput: one item per cycle unless res_full is high; edge reads feed the next address.
// Reset: arst_n clears control state, then the transition table and the alphabet are swept
// one entry per cycle (MAX_STATES * 2**SYMBOL_BITS in all, 4096 by default) while full is high.
// Configuration writes are taken at any time, including during that sweep.
`default_nettype none
`include "assert_macros.svh"

module table_driven_dfa_matcher_core #(
	parameter int MAX_STATES  = dfam_pkg::DEFAULT_MAX_STATES,
	parameter int SYMBOL_BITS = dfam_pkg::DEFAULT_SYMBOL_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire dfam_pkg::item_t                  cmd,
	output logic                                  empty,
	input  wire logic                             pop,
	output dfam_pkg::result_t                     res,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [dfam_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [dfam_pkg::PDATA_W-1:0]     pwdata,
	output logic      [dfam_pkg::PDATA_W-1:0]     prdata,
	output logic                                  pready
);

	logic [dfam_pkg::NSTATES_W-1:0]   num_states_q;
	logic [dfam_pkg::STATE_FLD_W-1:0] start_state_q;
	logic [dfam_pkg::MASK_W-1:0]      final_mask_q;
	logic                             cfg_wr;
	logic [1:0]                       reg_idx;

	dfam_pkg::cls_t    cls;
	logic              cls_valid;
	logic              cls_pop;
	logic              clearing;
	dfam_pkg::result_t res_in;
	logic              res_push;
	logic              res_full;
	logic              verdict_code;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= dfam_pkg::NSTATES_W'(1);
			start_state_q <= '0;
			final_mask_q  <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				dfam_pkg::REG_NUM_STATES: begin
					num_states_q <= pwdata[dfam_pkg::NSTATES_W-1:0];
				end
				dfam_pkg::REG_START_STATE: begin
					start_state_q <= pwdata[dfam_pkg::STATE_FLD_W-1:0];
				end
				dfam_pkg::REG_FINAL_MASK: begin
					final_mask_q <= pwdata[dfam_pkg::MASK_W-1:0];
				end
				default: begin
					final_mask_q <= final_mask_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dfam_pkg::REG_NUM_STATES: begin
				prdata = dfam_pkg::PDATA_W'(num_states_q);
			end
			dfam_pkg::REG_START_STATE: begin
				prdata = dfam_pkg::PDATA_W'(start_state_q);
			end
			dfam_pkg::REG_FINAL_MASK: begin
				prdata = dfam_pkg::PDATA_W'(final_mask_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	dfam_front #(
		.MAX_STATES (MAX_STATES),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cmd        (cmd),
		.full       (full),
		.hold       (clearing),
		.num_states (num_states_q),
		.start_state(start_state_q),
		.cls_pop    (cls_pop),
		.cls        (cls),
		.cls_valid  (cls_valid)
	);

	dfam_back #(
		.MAX_STATES (MAX_STATES),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cls        (cls),
		.cls_valid  (cls_valid),
		.cls_pop    (cls_pop),
		.num_states (num_states_q),
		.start_state(start_state_q),
		.final_mask (final_mask_q),
		.clearing   (clearing),
		.res_out    (res_in),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	dfam_fifo #(
		.WIDTH ($bits(dfam_pkg::result_t)),
		.DEPTH (dfam_pkg::RES_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res),
		.empty (empty)
	);

	assign verdict_code = (res_in.status == dfam_pkg::ST_ACCEPT) |
	                      (res_in.status == dfam_pkg::ST_REJECT) |
	                      (res_in.status == dfam_pkg::ST_BAD_STRING_SYM);

	`DFAM_ASSERT_IMPLY(a_res_no_overflow, res_push, !res_full, "result beat into a full queue")
	`DFAM_ASSERT_IMPLY(a_cmd_pop_valid, cls_pop, cls_valid, "command popped from an empty queue")
	`DFAM_ASSERT_IMPLY(a_no_pop_clearing, cls_pop, !clearing, "command issued during table clear")
	`DFAM_ASSERT_IMPLY(a_verdict_code, res_push && res_in.done_res, verdict_code, "bad verdict")

endmodule

`default_nettype wire

[rtl/dfam_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used for the transition table and the alphabet.
`default_nettype none

module dfam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/dfam_fifo.sv]
// Small register-based FIFO used for the command queue and the result queue.
// Standalone; width and depth come from the instantiating module.
`default_nettype none

module dfam_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/dfam_front.sv]
// Front end: classifies each accepted item against the configuration and queues it.
// Depends on dfam_pkg and dfam_fifo.
`default_nettype none

module dfam_front #(
	parameter int MAX_STATES  = dfam_pkg::DEFAULT_MAX_STATES,
	parameter int SYMBOL_BITS = dfam_pkg::DEFAULT_SYMBOL_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	input  wire dfam_pkg::item_t                      cmd,
	output logic                                      full,
	input  wire logic                                 hold,
	input  wire logic [dfam_pkg::NSTATES_W-1:0]       num_states,
	input  wire logic [dfam_pkg::STATE_FLD_W-1:0]     start_state,
	input  wire logic                                 cls_pop,
	output dfam_pkg::cls_t                            cls,
	output logic                                      cls_valid
);

	dfam_pkg::cls_t cls_in;
	logic           q_full;
	logic           q_empty;

	// Checks use configuration the user keeps stable, unenforced, while items flow.
	always_comb begin
		cls_in.opcode       = cmd.opcode;
		cls_in.symbol       = cmd.symbol;
		cls_in.from_state   = cmd.from_state;
		cls_in.to_state     = cmd.to_state;
		cls_in.last         = cmd.last;
		cls_in.sym_in_range = ((cmd.symbol >> SYMBOL_BITS) == '0);
		cls_in.from_ok      = dfam_pkg::state_known(cmd.from_state, num_states, MAX_STATES);
		cls_in.to_ok        = dfam_pkg::state_known(cmd.to_state, num_states, MAX_STATES);
		cls_in.start_ok     = dfam_pkg::state_known(start_state, num_states, MAX_STATES);
	end

	// No beat is taken while the transition table is being cleared.
	assign full      = q_full | hold;
	assign cls_valid = ~q_empty;

	dfam_fifo #(
		.WIDTH ($bits(dfam_pkg::cls_t)),
		.DEPTH (dfam_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push & ~hold),
		.wdata (cls_in),
		.full  (q_full),
		.pop   (cls_pop),
		.rdata (cls),
		.empty (q_empty)
	);

endmodule

`default_nettype wire

[rtl/dfam_back.sv]
// Back end: transition table lookup and update, alphabet, and string verdict logic.
// Depends on dfam_pkg and dfam_ram.
`default_nettype none

module dfam_back #(
	parameter int MAX_STATES  = dfam_pkg::DEFAULT_MAX_STATES,
	parameter int SYMBOL_BITS = dfam_pkg::DEFAULT_SYMBOL_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire dfam_pkg::cls_t                   cls,
	input  wire logic                             cls_valid,
	output logic                                  cls_pop,
	input  wire logic [dfam_pkg::NSTATES_W-1:0]   num_states,
	input  wire logic [dfam_pkg::STATE_FLD_W-1:0] start_state,
	input  wire logic [dfam_pkg::MASK_W-1:0]      final_mask,
	output logic                                  clearing,
	output dfam_pkg::result_t                     res_out,
	output logic                                  res_push,
	input  wire logic                             res_full
);

	localparam int SYM_COUNT  = 1 << SYMBOL_BITS;
	localparam int STATE_W    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int EDGE_AW    = STATE_W + SYMBOL_BITS;
	localparam int EDGE_DEPTH = MAX_STATES * SYM_COUNT;
	localparam int EDGE_W     = 1 + dfam_pkg::STATE_FLD_W;

	// Table clearing pass after reset.
	logic                clear_q;
	logic [EDGE_AW-1:0]  clr_addr_q;

	// String progress.
	logic                             in_string_q;
	logic                             bad_q;
	logic                             rej_q;
	logic [dfam_pkg::STATE_FLD_W-1:0] cur_q;

	// Stage after the table read.
	logic               valid_s1;
	dfam_pkg::cls_t     item_s1;
	logic [EDGE_AW-1:0] addr_s1;
	logic               fwd_s1;
	logic [EDGE_W-1:0]  fwd_data_s1;
	logic               fwd_alpha_s1;

	logic                             a_fire;
	logic                             b_fire;
	logic [EDGE_AW-1:0]               a_addr;
	logic [dfam_pkg::STATE_FLD_W-1:0] a_state;
	logic [SYMBOL_BITS-1:0]           a_sym;
	logic [EDGE_W-1:0]                ram_rdata;
	logic [EDGE_W-1:0]                edge_rd;
	logic                             ram_we;
	logic [EDGE_AW-1:0]               ram_waddr;
	logic [EDGE_W-1:0]                ram_wdata;

	logic                             alpha_rdata;
	logic                             alpha_rd;
	logic                             alpha_we;
	logic [SYMBOL_BITS-1:0]           alpha_waddr;
	logic                             alpha_wdata;

	logic [SYMBOL_BITS-1:0]           sym_idx_s1;
	logic                             sym_ok;
	logic                             alpha_set;
	logic                             we_item;
	logic                             nx_in;
	logic                             nx_bad;
	logic                             nx_rej;
	logic [dfam_pkg::STATE_FLD_W-1:0] nx_cur;
	dfam_pkg::status_t                status;
	logic                             done;

	assign clearing = clear_q;
	assign b_fire   = valid_s1 & ~res_full;
	assign a_fire   = cls_valid & ~clear_q & (~valid_s1 | b_fire);
	assign cls_pop  = a_fire;

	assign sym_idx_s1 = item_s1.symbol[SYMBOL_BITS-1:0];
	assign alpha_rd   = fwd_alpha_s1 | alpha_rdata;
	assign sym_ok     = item_s1.sym_in_range & alpha_rd;
	assign edge_rd    = fwd_s1 ? fwd_data_s1 : ram_rdata;

	always_comb begin
		nx_in     = in_string_q;
		nx_bad    = bad_q;
		nx_rej    = rej_q;
		nx_cur    = cur_q;
		status    = dfam_pkg::ST_OK;
		done      = 1'b0;
		we_item   = 1'b0;
		alpha_set = 1'b0;
		if (valid_s1) begin
			case (item_s1.opcode)
				dfam_pkg::OP_ADD_SYM: begin
					alpha_set = item_s1.sym_in_range;
				end
				dfam_pkg::OP_ADD_TRANS: begin
					if (!sym_ok) begin
						status = dfam_pkg::ST_BAD_TRANS_SYM;
					end else if (!item_s1.from_ok) begin
						status = dfam_pkg::ST_BAD_FROM;
					end else if (!item_s1.to_ok) begin
						status = dfam_pkg::ST_BAD_TO;
					end else begin
						// Only the first write to an entry counts.
						we_item = ~edge_rd[EDGE_W-1];
					end
				end
				dfam_pkg::OP_FEED: begin
					if (!in_string_q) begin
						nx_in  = 1'b1;
						nx_bad = 1'b0;
						nx_cur = start_state;
						nx_rej = ~item_s1.start_ok;
					end
					if (!sym_ok) begin
						nx_bad = 1'b1;
					end else if (!nx_rej) begin
						if (!dfam_pkg::state_known(nx_cur, num_states, MAX_STATES)) begin
							nx_rej = 1'b1;
						end else if (edge_rd[EDGE_W-1]) begin
							nx_cur = edge_rd[dfam_pkg::STATE_FLD_W-1:0];
						end else begin
							nx_rej = 1'b1;
						end
					end
					if (item_s1.last) begin
						done  = 1'b1;
						nx_in = 1'b0;
						if (nx_bad) begin
							status = dfam_pkg::ST_BAD_STRING_SYM;
						end else if (nx_rej) begin
							status = dfam_pkg::ST_REJECT;
						end else if (final_mask[nx_cur]) begin
							status = dfam_pkg::ST_ACCEPT;
						end else begin
							status = dfam_pkg::ST_REJECT;
						end
					end
				end
				default: begin
					status = dfam_pkg::ST_OK;
				end
			endcase
		end
	end

	assign a_sym = cls.symbol[SYMBOL_BITS-1:0];

	// Loads use from_state; else the state left in the later stage, or start_state.
	always_comb begin
		if (cls.opcode == dfam_pkg::OP_ADD_TRANS) begin
			a_state = cls.from_state;
		end else if (nx_in) begin
			a_state = nx_cur;
		end else begin
			a_state = start_state;
		end
		a_addr = {STATE_W'(a_state), a_sym};
	end

	assign ram_we    = clear_q | (b_fire & we_item);
	assign ram_waddr = clear_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clear_q ? '0 : {1'b1, item_s1.to_state};

	dfam_ram #(
		.WIDTH(EDGE_W),
		.DEPTH(EDGE_DEPTH)
	) u_edge_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (a_fire),
		.raddr(a_addr),
		.rdata(ram_rdata)
	);

	// The alphabet is cleared by the same sweep as the transition table.
	assign alpha_we    = clear_q | (b_fire & alpha_set);
	assign alpha_waddr = clear_q ? clr_addr_q[SYMBOL_BITS-1:0] : sym_idx_s1;
	assign alpha_wdata = ~clear_q;

	dfam_ram #(
		.WIDTH(1),
		.DEPTH(SYM_COUNT)
	) u_alpha_ram (
		.clk  (clk),
		.we   (alpha_we),
		.waddr(alpha_waddr),
		.wdata(alpha_wdata),
		.re   (a_fire),
		.raddr(a_sym),
		.rdata(alpha_rdata)
	);

	assign res_push         = b_fire;
	assign res_out.status   = status;
	assign res_out.done_res = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			if (clr_addr_q == EDGE_AW'(EDGE_DEPTH - 1)) begin
				clear_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
			bad_q       <= 1'b0;
			rej_q       <= 1'b0;
			cur_q       <= '0;
		end else if (b_fire) begin
			in_string_q <= nx_in;
			bad_q       <= nx_bad;
			rej_q       <= nx_rej;
			cur_q       <= nx_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			fwd_s1       <= 1'b0;
			fwd_alpha_s1 <= 1'b0;
		end else begin
			if (a_fire) begin
				valid_s1     <= 1'b1;
				// The RAMs return old data when the entry is written in the same cycle.
				fwd_s1       <= b_fire & we_item & (addr_s1 == a_addr);
				fwd_alpha_s1 <= b_fire & alpha_set & (sym_idx_s1 == a_sym);
			end else if (b_fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (a_fire) begin
			item_s1     <= cls;
			addr_s1     <= a_addr;
			fwd_data_s1 <= {1'b1, item_s1.to_state};
		end
	end

endmodule

`default_nettype wire

[bench/tb_table_driven_dfa_matcher_core.sv]
// Self-checking bench for table_driven_dfa_matcher_core: directed and random command beats,
// checked against an in-bench DFA predictor. Depends on dfam_pkg and the core RTL only.
module tb_table_driven_dfa_matcher_core;

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [7:0] SYM_A = 8'h61;
	localparam logic [7:0] SYM_B = 8'h62;
	localparam logic [7:0] SYM_Z = 8'h7a;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	dfam_pkg::item_t cmd;
	logic empty;
	logic pop;
	dfam_pkg::result_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dfam_pkg::PADDR_W-1:0] paddr;
	logic [dfam_pkg::PDATA_W-1:0] pwdata;
	logic [dfam_pkg::PDATA_W-1:0] prdata;
	logic pready;

	// Predictor copy of the matcher state and its registers.
	logic alpha_set [256];
	logic trans_ok [16][256];
	logic [3:0] trans_dst [16][256];
	logic [3:0] cur_st;
	logic rej_seen;
	logic bad_sym_seen;
	logic in_str;
	logic [4:0] cfg_nstates;
	logic [3:0] cfg_start;
	logic [15:0] cfg_final;

	dfam_pkg::result_t expected_res_q [$];
	dfam_pkg::result_t want_res;
	logic [7:0] sym_pool [8];
	int err_cnt;
	int cycle_cnt;
	int send_idle_pct;
	int pop_stall_pct;
	int hold_left;

	table_driven_dfa_matcher_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.empty(empty),
		.pop(pop),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("** table_driven_dfa_matcher_core: FAILED **");
		$finish;
	end

	task automatic report_fail(input string msg);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("%s", msg);
		end
	endtask

	function automatic int known_cnt();
		return (cfg_nstates < 5'd16) ? int'(cfg_nstates) : 16;
	endfunction

	task automatic clear_model();
		for (int s = 0; s < 256; s++) begin
			alpha_set[s] = 1'b0;
			for (int q = 0; q < 16; q++) begin
				trans_ok[q][s] = 1'b0;
				trans_dst[q][s] = 4'd0;
			end
		end
		cur_st = 4'd0;
		rej_seen = 1'b0;
		bad_sym_seen = 1'b0;
		in_str = 1'b0;
		cfg_nstates = 5'd1;
		cfg_start = 4'd0;
		cfg_final = 16'd0;
	endtask

	// Advances the predicted DFA by one command and returns the result it should produce.
	function automatic dfam_pkg::result_t dfa_predict(input dfam_pkg::item_t it);
		dfam_pkg::result_t r;
		int known;
		known = known_cnt();
		r.status = dfam_pkg::ST_OK;
		r.done_res = 1'b0;
		case (it.opcode)
			dfam_pkg::OP_ADD_SYM: begin
				alpha_set[it.symbol] = 1'b1;
			end
			dfam_pkg::OP_ADD_TRANS: begin
				if (!alpha_set[it.symbol]) begin
					r.status = dfam_pkg::ST_BAD_TRANS_SYM;
				end else if (int'(it.from_state) >= known) begin
					r.status = dfam_pkg::ST_BAD_FROM;
				end else if (int'(it.to_state) >= known) begin
					r.status = dfam_pkg::ST_BAD_TO;
				end else if (!trans_ok[it.from_state][it.symbol]) begin
					trans_ok[it.from_state][it.symbol] = 1'b1;
					trans_dst[it.from_state][it.symbol] = it.to_state;
				end
			end
			dfam_pkg::OP_FEED: begin
				if (!in_str) begin
					in_str = 1'b1;
					bad_sym_seen = 1'b0;
					cur_st = cfg_start;
					rej_seen = (int'(cfg_start) >= known);
				end
				if (!alpha_set[it.symbol]) begin
					bad_sym_seen = 1'b1;
				end else if (!rej_seen) begin
					// A current state beyond a shrunken state count counts as a missing edge.
					if (int'(cur_st) >= known) begin
						rej_seen = 1'b1;
					end else if (trans_ok[cur_st][it.symbol]) begin
						cur_st = trans_dst[cur_st][it.symbol];
					end else begin
						rej_seen = 1'b1;
					end
				end
				if (it.last) begin
					r.done_res = 1'b1;
					in_str = 1'b0;
					if (bad_sym_seen) begin
						r.status = dfam_pkg::ST_BAD_STRING_SYM;
					end else if (rej_seen) begin
						r.status = dfam_pkg::ST_REJECT;
					end else if (cfg_final[cur_st]) begin
						r.status = dfam_pkg::ST_ACCEPT;
					end else begin
						r.status = dfam_pkg::ST_REJECT;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Result side: random stalls, plus a counted hold-off requested by the pressure test.
	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else begin
				pop = ($urandom_range(99) >= pop_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_res_q.size() == 0) begin
				report_fail($sformatf("unexpected result beat: status=%0d done_res=%0d",
					res.status, res.done_res));
			end else begin
				want_res = expected_res_q.pop_front();
				if (res.status !== want_res.status || res.done_res !== want_res.done_res) begin
					report_fail($sformatf(
						"result mismatch: expected status=%0d done_res=%0d, got %0d %0d",
						want_res.status, want_res.done_res, res.status, res.done_res));
				end
			end
		end
	end

	// Called and left at a falling edge; push is low on return.
	task automatic send_cmd(input dfam_pkg::item_t it);
		dfam_pkg::result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
		end
		push = 1'b1;
		cmd = it;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		pred = dfa_predict(it);
		expected_res_q.insert(expected_res_q.size(), pred);
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic wait_all_results();
		push = 1'b0;
		while (expected_res_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
	                        output logic [31:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = dfam_pkg::PADDR_W'({idx, 2'b00});
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Writes a register, updates the predictor copy and reads the value back.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] mask;
		apb_xfer(1'b1, idx, value, rd);
		case (idx)
			dfam_pkg::REG_NUM_STATES: begin
				cfg_nstates = value[4:0];
				mask = 32'h1f;
			end
			dfam_pkg::REG_START_STATE: begin
				cfg_start = value[3:0];
				mask = 32'hf;
			end
			default: begin
				cfg_final = value[15:0];
				mask = 32'hffff;
			end
		endcase
		apb_xfer(1'b0, idx, 32'd0, rd);
		if (rd !== (value & mask)) begin
			report_fail($sformatf("register %0d readback: expected %0h, got %0h",
				idx, value & mask, rd));
		end
	endtask

	function automatic dfam_pkg::item_t mk_cmd(input logic [1:0] op, input logic [7:0] sym,
	                                           input logic [3:0] from, input logic [3:0] to,
	                                           input logic last);
		dfam_pkg::item_t it;
		it.opcode = op;
		it.symbol = sym;
		it.from_state = from;
		it.to_state = to;
		it.last = last;
		return it;
	endfunction

	function automatic logic [7:0] pool_sym(input int any_pct);
		if ($urandom_range(99) < any_pct) begin
			return 8'($urandom_range(255));
		end
		return sym_pool[$urandom_range(7)];
	endfunction

	function automatic logic [3:0] rand_state();
		if ($urandom_range(3) != 0) begin
			return 4'($urandom_range(known_cnt() - 1));
		end
		return 4'($urandom_range(15));
	endfunction

	function automatic dfam_pkg::item_t rand_cmd(input logic [1:0] op);
		return mk_cmd(op, pool_sym((op == dfam_pkg::OP_ADD_SYM) ? 30 : 10), rand_state(),
			rand_state(), 1'($urandom_range(1)));
	endfunction

	function automatic dfam_pkg::item_t rand_noise();
		case ($urandom_range(2))
			0: return rand_cmd(dfam_pkg::OP_ADD_SYM);
			1: return rand_cmd(dfam_pkg::OP_ADD_TRANS);
			default: return rand_cmd(OP_UNUSED);
		endcase
	endfunction

	task automatic test_directed_basics();
		write_reg(dfam_pkg::REG_NUM_STATES, 32'd4);
		write_reg(dfam_pkg::REG_START_STATE, 32'd0);
		write_reg(dfam_pkg::REG_FINAL_MASK, 32'h0004);
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_SYM, SYM_A, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_SYM, SYM_B, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_SYM, 8'h00, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_SYM, 8'hff, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_A, 4'd0, 4'd1, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_B, 4'd1, 4'd2, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_A, 4'd2, 4'd2, 1'b0));
		// The second load of an existing entry must be ignored.
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_A, 4'd0, 4'd3, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_Z, 4'd0, 4'd1, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_A, 4'd15, 4'd1, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_B, 4'd0, 4'd15, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_A, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_B, 4'd0, 4'd0, 1'b1));
		// Missing edge on the final byte still rejects.
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_A, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_A, 4'd0, 4'd0, 1'b1));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_A, 4'd0, 4'd0, 1'b1));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_A, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_Z, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_B, 4'd0, 4'd0, 1'b1));
		send_cmd(mk_cmd(OP_UNUSED, 8'hff, 4'd15, 4'd15, 1'b1));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_B, 4'd0, 4'd0, 1'b1));
		// An edge loaded in the middle of a string applies to the next byte.
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_A, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, 8'hff, 4'd1, 4'd2, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, 8'hff, 4'd0, 4'd0, 1'b1));
		wait_all_results();
	endtask

	task automatic test_register_extremes();
		write_reg(dfam_pkg::REG_NUM_STATES, 32'd16);
		write_reg(dfam_pkg::REG_START_STATE, 32'd15);
		write_reg(dfam_pkg::REG_FINAL_MASK, 32'hffff);
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, 8'hff, 4'd15, 4'd15, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, 8'h00, 4'd15, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, 8'h00, 4'd0, 4'd15, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, 8'hff, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, 8'h00, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, 8'h00, 4'd0, 4'd0, 1'b1));
		wait_all_results();
		write_reg(dfam_pkg::REG_FINAL_MASK, 32'h0000);
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, 8'hff, 4'd0, 4'd0, 1'b1));
		wait_all_results();
		// Start state beyond the state count rejects a string; a bad symbol still takes precedence.
		write_reg(dfam_pkg::REG_NUM_STATES, 32'd4);
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_A, 4'd0, 4'd0, 1'b1));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_Z, 4'd0, 4'd0, 1'b1));
		wait_all_results();
		// Shrink the state count while a string sits in state 15.
		write_reg(dfam_pkg::REG_NUM_STATES, 32'd16);
		write_reg(dfam_pkg::REG_FINAL_MASK, 32'hffff);
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, 8'hff, 4'd0, 4'd0, 1'b0));
		wait_all_results();
		write_reg(dfam_pkg::REG_NUM_STATES, 32'd4);
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, 8'hff, 4'd0, 4'd0, 1'b1));
		wait_all_results();
		write_reg(dfam_pkg::REG_NUM_STATES, 32'd1);
		write_reg(dfam_pkg::REG_START_STATE, 32'd0);
		write_reg(dfam_pkg::REG_FINAL_MASK, 32'h0001);
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_B, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_B, 4'd0, 4'd1, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_ADD_TRANS, SYM_B, 4'd1, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_B, 4'd0, 4'd0, 1'b0));
		send_cmd(mk_cmd(dfam_pkg::OP_FEED, SYM_B, 4'd0, 4'd0, 1'b1));
		wait_all_results();
	endtask

	// Mostly complete strings over a small working alphabet, mixed with table loads and noise.
	task automatic send_random_mix(input int n_items);
		int n;
		int len;
		int kind;
		int k;
		n = 0;
		while (n < n_items) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				send_cmd(rand_cmd(dfam_pkg::OP_ADD_SYM));
				n++;
			end else if (kind < 24) begin
				send_cmd(rand_cmd(dfam_pkg::OP_ADD_TRANS));
				n++;
			end else if (kind < 28) begin
				send_cmd(rand_cmd(OP_UNUSED));
				n++;
			end else begin
				len = $urandom_range(6, 1);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(19) == 0) begin
						send_cmd(rand_noise());
						n++;
					end
					send_cmd(mk_cmd(dfam_pkg::OP_FEED, pool_sym(10), 4'($urandom_range(15)),
						4'($urandom_range(15)), k == len - 1));
					n++;
				end
			end
		end
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
		wait_all_results();
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		write_reg(dfam_pkg::REG_NUM_STATES,
			($urandom_range(3) == 0) ? 32'd16 : $urandom_range(16, 1));
		if ($urandom_range(9) == 0) begin
			write_reg(dfam_pkg::REG_START_STATE, $urandom_range(15));
		end else begin
			write_reg(dfam_pkg::REG_START_STATE, $urandom_range(known_cnt() - 1));
		end
		write_reg(dfam_pkg::REG_FINAL_MASK, $urandom_range(16'hffff));
		send_random_mix(n_items);
		wait_all_results();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		pop_stall_pct = 0;
		@(posedge clk);
		hold_left = 150;
		@(negedge clk);
		send_random_mix(40);
		wait_all_results();
	endtask

	task automatic test_pause_drain();
		send_idle_pct = 0;
		pop_stall_pct = 35;
		send_random_mix(15);
		wait_all_results();
		send_random_mix(15);
		wait_all_results();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_cnt = 0;
		cycle_cnt = 0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		hold_left = 0;
		clear_model();
		sym_pool[0] = SYM_A;
		sym_pool[1] = SYM_B;
		sym_pool[2] = 8'h00;
		sym_pool[3] = 8'hff;
		for (int p = 4; p < 8; p++) begin
			sym_pool[p] = 8'($urandom_range(255));
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed_basics();
		test_register_extremes();
		test_random_phase(0, 0, 220);
		test_random_phase(80, 0, 220);
		test_random_phase(0, 80, 220);
		test_random_phase(35, 35, 220);
		test_backpressure();
		test_pause_drain();
		wait_all_results();
		repeat (10) @(negedge clk);
		if (err_cnt == 0 && expected_res_q.size() == 0) begin
			$display("** table_driven_dfa_matcher_core: PASSED **");
		end else begin
			$display("** table_driven_dfa_matcher_core: FAILED **");
		end
		$finish;
	end

endmodule
